FILE: hdl/mfde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_pkg
// shared constants, types and helpers of the monochrome framebuffer engine
// ----------------------------------------------------------------------------
package mfde_pkg;

    localparam int FB_WIDTH  = 128;
    localparam int FB_HEIGHT = 64;
    localparam int ROW_W     = $clog2(FB_HEIGHT);
    localparam int COL_W     = $clog2(FB_WIDTH);

    localparam logic [2:0] REQ_FILL_FRAME = 3'd0;
    localparam logic [2:0] REQ_SET_PIXEL  = 3'd1;
    localparam logic [2:0] REQ_FILL_RECT  = 3'd2;
    localparam logic [2:0] REQ_OUTLINE    = 3'd3;
    localparam logic [2:0] REQ_BITMAP     = 3'd4;
    localparam logic [2:0] REQ_READ_PIXEL = 3'd5;

    typedef logic [FB_WIDTH-1:0] row_t;

    // controller to datapath
    typedef struct packed {
        logic             load;      // latch the request
        logic             clear_run; // write the ink to the whole row at row_idx
        logic             zero_run;  // write zeros to the whole row at row_idx
        logic             rd;        // issue row read at row_idx
        logic             wr;        // merge and write row at row_idx
        logic [ROW_W-1:0] row_idx;
        logic             take_pix;  // latch the read pixel from read data
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0]       req_type;
        logic [ROW_W-1:0] y_first;
        logic [ROW_W-1:0] y_last;
        logic             span_ok;   // at least one row to visit
    } stat_t;

    // mask of columns [x0, x1) clipped to the frame, on 13-bit signed bounds
    function automatic row_t span_mask(input logic signed [12:0] x0,
                                       input logic signed [12:0] x1);
        row_t m;
        m = '0;
        for (int c = 0; c < FB_WIDTH; c++) begin
            if ($signed(13'(c)) >= x0 && $signed(13'(c)) < x1) begin
                m[c] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/mfde_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_datapath
// request register, row-wide frame memory and per-row write mask
// ----------------------------------------------------------------------------
module mfde_datapath (
    input  wire logic               aclk,
    input  wire logic [2:0]         s_req_type,
    input  wire logic signed [11:0] s_pos_x,
    input  wire logic signed [11:0] s_pos_y,
    input  wire logic [10:0]        s_rect_width,
    input  wire logic [10:0]        s_rect_height,
    input  wire logic               s_ink,
    input  wire logic [7:0]         s_bitmap_byte,
    input  wire logic [3:0]         s_bitmap_count,
    input  wire mfde_pkg::cmd_t     cmd,
    output mfde_pkg::stat_t         stat,
    output logic                    pix
);
    localparam int RW = mfde_pkg::ROW_W;

    logic [2:0]         type_reg;
    logic signed [12:0] x_reg, y_reg, w_reg, h_reg;
    logic               ink_reg;
    logic [7:0]         bits_reg;
    logic [3:0]         cnt_reg;
    logic               pix_reg;

    mfde_pkg::row_t mem [mfde_pkg::FB_HEIGHT];
    mfde_pkg::row_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            type_reg <= s_req_type;
            x_reg    <= 13'(s_pos_x);
            y_reg    <= 13'(s_pos_y);
            w_reg    <= $signed({2'b00, s_rect_width});
            h_reg    <= $signed({2'b00, s_rect_height});
            ink_reg  <= s_ink;
            bits_reg <= s_bitmap_byte;
            cnt_reg  <= (s_bitmap_count > 4'd8) ? 4'd8 : s_bitmap_count;
        end
    end

    // row span of the command
    logic signed [12:0] ys, ye; // [ys, ye]
    always_comb begin
        ys = y_reg;
        ye = y_reg;
        case (type_reg)
            mfde_pkg::REQ_FILL_RECT: ye = y_reg + h_reg - 13'sd1;
            mfde_pkg::REQ_OUTLINE: begin
                ye = y_reg + h_reg - 13'sd1;
                if (h_reg == 13'sd0) begin
                    ys = y_reg - 13'sd1;
                    ye = y_reg;
                end
            end
            default: ;
        endcase
    end

    logic signed [12:0] ysc, yec;
    always_comb begin
        ysc = (ys < 13'sd0) ? 13'sd0 : ys;
        yec = (ye > 13'(mfde_pkg::FB_HEIGHT - 1)) ? 13'(mfde_pkg::FB_HEIGHT - 1) : ye;
        stat.req_type = type_reg;
        stat.y_first  = ysc[RW-1:0];
        stat.y_last   = yec[RW-1:0];
        stat.span_ok  = (ysc <= yec) && (ys <= ye);
    end

    // write mask for the current row
    logic signed [12:0] r;
    mfde_pkg::row_t     mask, hspan, bm;
    always_comb begin
        r     = $signed({{(13-RW){1'b0}}, cmd.row_idx});
        hspan = mfde_pkg::span_mask(x_reg, x_reg + w_reg);
        bm    = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < 32'(cnt_reg) && bits_reg[7-i]) begin
                bm = bm | mfde_pkg::span_mask(x_reg + 13'(i), x_reg + 13'(i + 1));
            end
        end
        mask = '0;
        case (type_reg)
            mfde_pkg::REQ_SET_PIXEL:
                if (r == y_reg) mask = mfde_pkg::span_mask(x_reg, x_reg + 13'sd1);
            mfde_pkg::REQ_FILL_RECT:
                if (r >= y_reg && r < y_reg + h_reg) mask = hspan;
            mfde_pkg::REQ_OUTLINE: begin
                if (r == y_reg || r == y_reg + h_reg - 13'sd1) mask = hspan;
                if (r >= y_reg && r < y_reg + h_reg) begin
                    mask = mask | mfde_pkg::span_mask(x_reg, x_reg + 13'sd1)
                                | mfde_pkg::span_mask(x_reg + w_reg - 13'sd1, x_reg + w_reg);
                end
            end
            mfde_pkg::REQ_BITMAP:
                if (r == y_reg) mask = bm;
            default: mask = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.zero_run) begin
            mem[cmd.row_idx] <= '0;
        end else if (cmd.clear_run) begin
            mem[cmd.row_idx] <= {mfde_pkg::FB_WIDTH{ink_reg}};
        end else if (cmd.wr) begin
            mem[cmd.row_idx] <= (rdata_reg & ~mask) | ({mfde_pkg::FB_WIDTH{ink_reg}} & mask);
        end
        if (cmd.rd) begin
            rdata_reg <= mem[cmd.row_idx];
        end
    end

    // read pixel select
    logic in_frame;
    always_comb begin
        in_frame = (x_reg >= 13'sd0) && (x_reg < 13'(mfde_pkg::FB_WIDTH))
                && (y_reg >= 13'sd0) && (y_reg < 13'(mfde_pkg::FB_HEIGHT));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pix_reg <= 1'b0;
        end else if (cmd.take_pix) begin
            pix_reg <= in_frame & rdata_reg[x_reg[mfde_pkg::COL_W-1:0]];
        end
    end
    assign pix = pix_reg;

endmodule
`default_nettype wire

FILE: hdl/mfde_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_ctrl
// sequencer: reset clearing pass, row read-modify-write walk, result handshake
// ----------------------------------------------------------------------------
module mfde_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [2:0]           m_ack_type,
    output mfde_pkg::cmd_t       cmd,
    input  wire mfde_pkg::stat_t stat
);
    localparam int RW = mfde_pkg::ROW_W;
    localparam logic [RW-1:0] LAST_ROW = RW'(mfde_pkg::FB_HEIGHT - 1);

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_DECODE, ST_READ, ST_WRITE, ST_FILL, ST_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic          mval_reg, mval_next;
    logic [2:0]    ack_reg, ack_next;

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        mval_next  = mval_reg;
        ack_next   = ack_reg;
        cmd        = '0;
        cmd.row_idx = row_reg;
        if (mval_reg && m_ready) mval_next = 1'b0;
        s_ready = (state_reg == ST_IDLE) && !(mval_reg && !m_ready);
        unique case (state_reg)
            ST_INIT: begin
                // ink_reg is unknown here, so write zeros directly
                cmd.zero_run = 1'b1;
                row_next = row_reg + RW'(1);
                if (row_reg == LAST_ROW) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (stat.req_type == mfde_pkg::REQ_FILL_FRAME) begin
                    row_next   = '0;
                    state_next = ST_FILL;
                end else if (stat.req_type == mfde_pkg::REQ_READ_PIXEL ||
                             (stat.span_ok && stat.req_type <= mfde_pkg::REQ_BITMAP)) begin
                    row_next   = stat.y_first;
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (stat.req_type == mfde_pkg::REQ_READ_PIXEL) begin
                    cmd.take_pix = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.wr = 1'b1;
                    if (row_reg == stat.y_last) begin
                        state_next = ST_DONE;
                    end else begin
                        row_next   = row_reg + RW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_FILL: begin
                cmd.clear_run = 1'b1;
                row_next = row_reg + RW'(1);
                if (row_reg == LAST_ROW) state_next = ST_DONE;
            end
            ST_DONE: begin
                mval_next  = 1'b1;
                ack_next   = stat.req_type;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            row_reg   <= '0;
            mval_reg  <= 1'b0;
            ack_reg   <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            mval_reg  <= mval_next;
            ack_reg   <= ack_next;
        end
    end

    assign m_valid    = mval_reg;
    assign m_ack_type = ack_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> !(mval_reg && !m_ready))
        else $error("result overwritten before taken");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr || cmd.clear_run || cmd.zero_run) |-> !cmd.rd)
        else $error("read and write in the same cycle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
endmodule
`default_nettype wire

FILE: hdl/mono_framebuffer_draw_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// 1-bit 128x64 framebuffer with fill, pixel, rectangle, outline, bitmap, read
// ----------------------------------------------------------------------------
// usage: one drawing command enters on the s_ channel (valid/ready) and one
// acknowledgement leaves on the m_ channel with the echoed type and, for a
// read command, the pixel value. one command is worked at a time.
// the frame is held as one memory word per row; each touched row of a drawing
// command is read, merged with the write mask and written back, and a read
// command only reads its row. a single pixel, bitmap byte or read touches one
// row and a full-height rectangle all 64; a fill frame writes every row
// without reading it, and a command that touches no row goes straight to the
// acknowledgement. the acknowledgement is raised once the last row is done.
// after reset a clearing pass writes zeros to all 64 rows and s_ready stays
// low meanwhile. a result waits in its output register while the receiver
// stalls; the next command is taken only once it has gone.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_req_type,
    input  wire logic signed [11:0] s_pos_x,
    input  wire logic signed [11:0] s_pos_y,
    input  wire logic [10:0]        s_rect_width,
    input  wire logic [10:0]        s_rect_height,
    input  wire logic               s_ink,
    input  wire logic [7:0]         s_bitmap_byte,
    input  wire logic [3:0]         s_bitmap_count,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_pixel_value,
    output logic [2:0]              m_ack_type
);
    mfde_pkg::cmd_t  cmd;
    mfde_pkg::stat_t stat;

    mfde_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .m_ack_type, .cmd, .stat
    );

    mfde_datapath u_dp (
        .aclk, .s_req_type, .s_pos_x, .s_pos_y, .s_rect_width, .s_rect_height,
        .s_ink, .s_bitmap_byte, .s_bitmap_count, .cmd, .stat,
        .pix(m_pixel_value)
    );
endmodule
`default_nettype wire
